[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk and the active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, masked while rst_n is low.
`define DFSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising edge of clk, also during reset.
`define DFSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/dfsc_pkg.sv]
// ----------------------------------------------------------------------------
// dfsc_pkg
// Types and constants shared by the dual fan speed controller modules.
// ----------------------------------------------------------------------------
package dfsc_pkg;

  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

  // Reset values of the configuration registers
  localparam int RST_CAP_OFF   = 640;
  localparam int RST_CAP_ON    = 720;
  localparam int RST_CAP_FULL  = 1120;
  localparam int RST_SINK_OFF  = 720;
  localparam int RST_SINK_ON   = 800;
  localparam int RST_SINK_FULL = 1280;
  localparam logic [PCT_W-1:0] RST_MIN_RUN  = 7'd20;
  localparam logic [PCT_W-1:0] RST_DEADBAND = 7'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP_OFF   = 3'd0,
    CFG_CAP_ON    = 3'd1,
    CFG_CAP_FULL  = 3'd2,
    CFG_SINK_OFF  = 3'd3,
    CFG_SINK_ON   = 3'd4,
    CFG_SINK_FULL = 3'd5,
    CFG_MIN_RUN   = 3'd6,
    CFG_DEADBAND  = 3'd7
  } cfg_idx_t;

  // Ramp unit response: one-cycle done strobe and the fan demand
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } ramp_rsp_t;

endpackage

[hw/rtl/dfsc_ramp.sv]
// ----------------------------------------------------------------------------
// dfsc_ramp
// Fan curve evaluation for one fan: off/hold/full classification, then a
// bit-serial minimum-run product and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfsc_ramp
  import dfsc_pkg::*;
#(
  parameter int TW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [TW-1:0] t_in,
  input  logic signed [TW-1:0] on_pt,
  input  logic signed [TW-1:0] full_pt,
  input  logic signed [TW-1:0] off_pt,
  input  logic [PCT_W-1:0]     last_pct,
  input  logic [PCT_W-1:0]     min_run,
  output ramp_rsp_t            rsp
);

  localparam int PW = TW + PCT_W;
  localparam int RW = TW + PCT_W + 1;
  localparam int CW = $clog2(PCT_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(PCT_W - 1);

  typedef enum logic [2:0] {
    R_IDLE,
    R_CLASS,
    R_PREP,
    R_MUL,
    R_CMP,
    R_DIV
  } rstate_t;

  rstate_t              state_r;
  logic signed [TW-1:0] t_r, on_r, full_r, off_r;
  logic [PCT_W-1:0]     last_r, minrun_r, mbits_r, q_r;
  logic [TW-1:0]        d_r, s_r;
  logic [PW-1:0]        hd_r, acc_r, mcand_r;
  logic [RW-1:0]        rem_r, dv_r;
  logic [CW-1:0]        cnt_r;
  ramp_rsp_t            rsp_r;

  logic signed [TW:0]   diff_d, diff_s;
  logic [PW-1:0]        d_ext, hd_w;
  logic [RW-1:0]        num_w;

  assign diff_d = {t_r[TW-1], t_r} - {on_r[TW-1], on_r};
  assign diff_s = {full_r[TW-1], full_r} - {on_r[TW-1], on_r};
  assign d_ext  = PW'(d_r);
  // 100*d as three shifted terms
  assign hd_w   = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
  // 200*d + s, the numerator of the half-up rounded ramp
  assign num_w  = {hd_r, 1'b0} + RW'(s_r);
  assign rsp    = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= R_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      rsp_r.done <= 1'b0;
      unique case (state_r)
        R_IDLE: begin
          if (start) begin
            t_r      <= t_in;
            on_r     <= on_pt;
            full_r   <= full_pt;
            off_r    <= off_pt;
            last_r   <= last_pct;
            minrun_r <= min_run;
            state_r  <= R_CLASS;
          end
        end
        R_CLASS: begin
          // off point wins, then hold band, then full speed, then the ramp
          priority if (t_r <= off_r) begin
            rsp_r.pct  <= PCT_ZERO;
            rsp_r.done <= 1'b1;
            state_r    <= R_IDLE;
          end else if (t_r < on_r) begin
            rsp_r.pct  <= last_r;
            rsp_r.done <= 1'b1;
            state_r    <= R_IDLE;
          end else if (t_r >= full_r) begin
            rsp_r.pct  <= PCT_FULL;
            rsp_r.done <= 1'b1;
            state_r    <= R_IDLE;
          end else if (diff_d == '0) begin
            rsp_r.pct  <= PCT_ZERO;
            rsp_r.done <= 1'b1;
            state_r    <= R_IDLE;
          end else begin
            d_r     <= diff_d[TW-1:0];
            s_r     <= diff_s[TW-1:0];
            state_r <= R_PREP;
          end
        end
        R_PREP: begin
          hd_r    <= hd_w;
          acc_r   <= '0;
          mcand_r <= PW'(s_r);
          mbits_r <= minrun_r;
          cnt_r   <= '0;
          state_r <= R_MUL;
        end
        R_MUL: begin
          // shift-add: one bit of the minimum run value per cycle
          if (mbits_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r <= mcand_r << 1;
          mbits_r <= mbits_r >> 1;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            state_r <= R_CMP;
          end
        end
        R_CMP: begin
          if (hd_r < acc_r) begin
            rsp_r.pct  <= minrun_r;
            rsp_r.done <= 1'b1;
            state_r    <= R_IDLE;
          end else begin
            rem_r   <= num_w;
            dv_r    <= RW'(s_r) << PCT_W;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= R_DIV;
          end
        end
        R_DIV: begin
          // restoring division by 2*s, one quotient bit per cycle
          if (rem_r >= dv_r) begin
            rem_r <= rem_r - dv_r;
          end
          q_r   <= {q_r[PCT_W-2:0], (rem_r >= dv_r)};
          dv_r  <= dv_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            rsp_r.pct  <= {q_r[PCT_W-2:0], (rem_r >= dv_r)};
            rsp_r.done <= 1'b1;
            state_r    <= R_IDLE;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  `DFSC_ASSERT(a_pct_range, rsp_r.done |-> (rsp_r.pct <= PCT_FULL), "ramp demand above full")
  `DFSC_ASSERT(a_start_idle, start |-> (state_r == R_IDLE), "ramp started while busy")
  `DFSC_ASSERT(a_div_nonzero, (state_r == R_DIV) |-> (dv_r != '0), "zero divisor in ramp")

endmodule

[hw/rtl/dual_fan_speed_controller_unit.sv]
// ----------------------------------------------------------------------------
// dual_fan_speed_controller_unit
// Fan curve with hysteresis, minimum run and command deadband for a
// capacitor fan and a heatsink fan.
// ----------------------------------------------------------------------------
// Usage:
//   One input item per control tick: 12 V present flag plus heatsink and two
//   board temperatures (signed, 1/16 degree C) with their valid flags. Each
//   item yields exactly one result item: both commanded percents and a write
//   flag per fan that marks a newly issued command.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low. in_stall is high while an item is being worked on.
//   One shared ramp unit evaluates the fans in turn; a ramp evaluation
//   may run a bit-serial product and then a bit-serial divider, so that
//   unit sets the item rate. Items are worked on one at a time.
//   The result sits in an output register; a new item is accepted while it
//   waits. If out_stall holds the previous result when the next one is done,
//   the block holds and waits; fan state is updated only when the result is
//   loaded into the output register.
//   Reset (synchronous, rst_n low) loads the default fan curves and clears
//   both last commands. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_fan_speed_controller_unit
  import dfsc_pkg::*;
#(
  parameter int TEMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [TEMP_WIDTH-1:0]        cfg_wdata,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_supply_present,
  input  logic signed [TEMP_WIDTH-1:0] in_sink_temp,
  input  logic                         in_sink_valid,
  input  logic signed [TEMP_WIDTH-1:0] in_board_a_temp,
  input  logic                         in_board_a_valid,
  input  logic signed [TEMP_WIDTH-1:0] in_board_b_temp,
  input  logic                         in_board_b_valid,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [PCT_W-1:0]             out_cap_percent,
  output logic                         out_cap_write,
  output logic [PCT_W-1:0]             out_sink_percent,
  output logic                         out_sink_write
);

  localparam int TW = TEMP_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAP_GO,
    S_CAP_WAIT,
    S_SINK_GO,
    S_SINK_WAIT,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [TW-1:0] cap_off_r, cap_on_r, cap_full_r;
  logic signed [TW-1:0] sink_off_r, sink_on_r, sink_full_r;
  logic [PCT_W-1:0]     min_run_r, deadband_r;

  // latched input item
  logic                 supply_r, sink_v_r, a_v_r, b_v_r;
  logic signed [TW-1:0] sink_t_r, a_t_r, b_t_r;

  // fan state and per-item demands
  logic [PCT_W-1:0]     cap_last_r, sink_last_r;
  logic [PCT_W-1:0]     cap_pct_r, sink_pct_r;

  // output register
  logic                 out_valid_r;
  logic [PCT_W-1:0]     out_cap_percent_r, out_sink_percent_r;
  logic                 out_cap_write_r, out_sink_write_r;

  // ramp unit hookup
  logic                 ramp_start;
  logic signed [TW-1:0] ramp_t, ramp_on, ramp_full, ramp_off;
  logic [PCT_W-1:0]     ramp_last, min_run_sat;
  ramp_rsp_t            rsp;

  logic                 in_accept, out_free;
  logic                 cap_any, cap_wr_w, sink_wr_w;
  logic signed [TW-1:0] board_hot;

  function automatic logic issue_cmd(input logic [PCT_W-1:0] pct,
                                     input logic [PCT_W-1:0] last,
                                     input logic [PCT_W-1:0] db);
    logic [PCT_W-1:0] pct_gap;
    pct_gap = (pct > last) ? (pct - last) : (last - pct);
    return ((pct == PCT_ZERO) && (last != PCT_ZERO)) ||
           ((pct != PCT_ZERO) && (pct_gap >= db));
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // hotter of the valid board sensors; a wins ties
  assign cap_any   = a_v_r || b_v_r;
  assign board_hot = (a_v_r && !(b_v_r && (b_t_r > a_t_r))) ? a_t_r : b_t_r;

  assign min_run_sat = (min_run_r > PCT_FULL) ? PCT_FULL : min_run_r;

  assign ramp_start = ((state_r == S_CAP_GO) && supply_r && cap_any) ||
                      ((state_r == S_SINK_GO) && supply_r && sink_v_r);
  assign ramp_t     = (state_r == S_CAP_GO) ? board_hot   : sink_t_r;
  assign ramp_on    = (state_r == S_CAP_GO) ? cap_on_r    : sink_on_r;
  assign ramp_full  = (state_r == S_CAP_GO) ? cap_full_r  : sink_full_r;
  assign ramp_off   = (state_r == S_CAP_GO) ? cap_off_r   : sink_off_r;
  assign ramp_last  = (state_r == S_CAP_GO) ? cap_last_r  : sink_last_r;

  assign cap_wr_w  = issue_cmd(cap_pct_r, cap_last_r, deadband_r);
  assign sink_wr_w = issue_cmd(sink_pct_r, sink_last_r, deadband_r);

  dfsc_ramp #(
    .TW (TW)
  ) u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ramp_start),
    .t_in     (ramp_t),
    .on_pt    (ramp_on),
    .full_pt  (ramp_full),
    .off_pt   (ramp_off),
    .last_pct (ramp_last),
    .min_run  (min_run_sat),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_last_r  <= PCT_ZERO;
      sink_last_r <= PCT_ZERO;
      cap_off_r   <= TW'(RST_CAP_OFF);
      cap_on_r    <= TW'(RST_CAP_ON);
      cap_full_r  <= TW'(RST_CAP_FULL);
      sink_off_r  <= TW'(RST_SINK_OFF);
      sink_on_r   <= TW'(RST_SINK_ON);
      sink_full_r <= TW'(RST_SINK_FULL);
      min_run_r   <= RST_MIN_RUN;
      deadband_r  <= RST_DEADBAND;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CAP_OFF:   cap_off_r   <= cfg_wdata;
          CFG_CAP_ON:    cap_on_r    <= cfg_wdata;
          CFG_CAP_FULL:  cap_full_r  <= cfg_wdata;
          CFG_SINK_OFF:  sink_off_r  <= cfg_wdata;
          CFG_SINK_ON:   sink_on_r   <= cfg_wdata;
          CFG_SINK_FULL: sink_full_r <= cfg_wdata;
          CFG_MIN_RUN:   min_run_r   <= cfg_wdata[PCT_W-1:0];
          CFG_DEADBAND:  deadband_r  <= cfg_wdata[PCT_W-1:0];
          default: ;
        endcase
      end

      // drop the result once the receiver takes it, unless the next one loads
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            supply_r <= in_supply_present;
            sink_t_r <= in_sink_temp;
            sink_v_r <= in_sink_valid;
            a_t_r    <= in_board_a_temp;
            a_v_r    <= in_board_a_valid;
            b_t_r    <= in_board_b_temp;
            b_v_r    <= in_board_b_valid;
            state_r  <= S_CAP_GO;
          end
        end
        S_CAP_GO: begin
          // no supply: demand zero; no valid board sensor: hold last
          if (ramp_start) begin
            state_r <= S_CAP_WAIT;
          end else begin
            cap_pct_r <= supply_r ? cap_last_r : PCT_ZERO;
            state_r   <= S_SINK_GO;
          end
        end
        S_CAP_WAIT: begin
          if (rsp.done) begin
            cap_pct_r <= rsp.pct;
            state_r   <= S_SINK_GO;
          end
        end
        S_SINK_GO: begin
          if (ramp_start) begin
            state_r <= S_SINK_WAIT;
          end else begin
            sink_pct_r <= supply_r ? sink_last_r : PCT_ZERO;
            state_r    <= S_DONE;
          end
        end
        S_SINK_WAIT: begin
          if (rsp.done) begin
            sink_pct_r <= rsp.pct;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          // apply the deadband and commit when the output register is free
          if (out_free) begin
            if (cap_wr_w) begin
              cap_last_r <= cap_pct_r;
            end
            if (sink_wr_w) begin
              sink_last_r <= sink_pct_r;
            end
            out_cap_percent_r  <= cap_wr_w ? cap_pct_r : cap_last_r;
            out_sink_percent_r <= sink_wr_w ? sink_pct_r : sink_last_r;
            out_cap_write_r    <= cap_wr_w;
            out_sink_write_r   <= sink_wr_w;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cap_percent  = out_cap_percent_r;
  assign out_cap_write    = out_cap_write_r;
  assign out_sink_percent = out_sink_percent_r;
  assign out_sink_write   = out_sink_write_r;

  `DFSC_ASSERT(a_last_match,
    out_valid_r |-> ((cap_last_r == out_cap_percent_r) && (sink_last_r == out_sink_percent_r)),
    "fan state differs from shown command")
  `DFSC_ASSERT(a_supply_stop,
    (out_valid_r && !$past(out_valid_r) && !supply_r) |->
      ((out_cap_percent_r == PCT_ZERO) && (out_sink_percent_r == PCT_ZERO)),
    "fan left running without supply")
  `DFSC_ASSERT(a_done_wait,
    rsp.done |-> ((state_r == S_CAP_WAIT) || (state_r == S_SINK_WAIT)),
    "ramp result arrived unexpectedly")

endmodule

[tb/tb_dual_fan_speed_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_fan_speed_controller_unit
// Drives control ticks into the dual fan speed controller and checks every
// result item against a cycle-free model of the fan curves kept in the bench.
// A short directed plan covers supply loss, missing sensors, the curve
// corners and odd register settings; random phases then reprogram all curve
// registers and push ticks that drift around the curve points, with random
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_dual_fan_speed_controller_unit;
  import dfsc_pkg::*;

  localparam int TW              = 16;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TAIL_CYCLES     = 64;
  localparam int CYCLE_LIMIT     = 1000000;

  // One control tick as seen on the input channel
  typedef struct {
    logic                 supply;
    logic signed [TW-1:0] sink_temp;
    logic                 sink_valid;
    logic signed [TW-1:0] a_temp;
    logic                 a_valid;
    logic signed [TW-1:0] b_temp;
    logic                 b_valid;
  } fan_reading_t;

  // One result item: both commanded percents and their write flags
  typedef struct {
    logic [PCT_W-1:0] cap_pct;
    logic             cap_wr;
    logic [PCT_W-1:0] sink_pct;
    logic             sink_wr;
  } fan_cmd_t;

  // Directed plan: either a register write or a tick, optionally with its
  // result typed in by hand
  typedef struct {
    bit           is_write;
    cfg_idx_t     idx;
    logic [TW-1:0] wdata;
    fan_reading_t rd;
    bit           typed;
    fan_cmd_t     want;
  } plan_step_t;

  typedef enum int {
    CURVE_TYPICAL,
    CURVE_FULL_SPAN,
    CURVE_STEEP,
    CURVE_OFF_ABOVE_ON,
    CURVE_FULL_BELOW_ON,
    CURVE_TOP_END,
    CURVE_WILD
  } curve_shape_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TW-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_supply_present = 1'b0;
  logic signed [TW-1:0] in_sink_temp = '0;
  logic                 in_sink_valid = 1'b0;
  logic signed [TW-1:0] in_board_a_temp = '0;
  logic                 in_board_a_valid = 1'b0;
  logic signed [TW-1:0] in_board_b_temp = '0;
  logic                 in_board_b_valid = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PCT_W-1:0]     out_cap_percent;
  logic                 out_cap_write;
  logic [PCT_W-1:0]     out_sink_percent;
  logic                 out_sink_write;

  // Register shadow and last commands of the bench's own fan model
  logic [TW-1:0]    cfg_shadow [8];
  logic [PCT_W-1:0] cap_cmd_now  = PCT_ZERO;
  logic [PCT_W-1:0] sink_cmd_now = PCT_ZERO;

  fan_cmd_t   pending_cmds [$];
  plan_step_t plan [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         stall_hold = 0;

  dual_fan_speed_controller_unit #(
    .TEMP_WIDTH(TW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_supply_present (in_supply_present),
    .in_sink_temp      (in_sink_temp),
    .in_sink_valid     (in_sink_valid),
    .in_board_a_temp   (in_board_a_temp),
    .in_board_a_valid  (in_board_a_valid),
    .in_board_b_temp   (in_board_b_temp),
    .in_board_b_valid  (in_board_b_valid),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cap_percent   (out_cap_percent),
    .out_cap_write     (out_cap_write),
    .out_sink_percent  (out_sink_percent),
    .out_sink_write    (out_sink_write)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fan model
  // ---------------------------------------------------------------------------

  // Demand of one fan from its curve; all ramp math is exact integer math
  function automatic logic [PCT_W-1:0] fan_demand(logic signed [TW-1:0] t,
                                                  logic signed [TW-1:0] off_pt,
                                                  logic signed [TW-1:0] on_pt,
                                                  logic signed [TW-1:0] full_pt,
                                                  logic [PCT_W-1:0] last);
    longint d, s, floor_run;
    floor_run = cfg_shadow[CFG_MIN_RUN][PCT_W-1:0];
    if (floor_run > PCT_FULL) floor_run = PCT_FULL;
    // The off test comes first, so an off point above the on point wins
    if (t <= off_pt) return PCT_ZERO;
    // Hysteresis band: hold whatever was commanded last
    if (t < on_pt) return last;
    if (t >= full_pt) return PCT_FULL;
    d = longint'(t) - longint'(on_pt);
    s = longint'(full_pt) - longint'(on_pt);
    if (d == 0) return PCT_ZERO;
    if (100 * d < floor_run * s) return PCT_W'(floor_run);
    // Ramp rounded half up
    return PCT_W'((200 * d + s) / (2 * s));
  endfunction

  // Stops go to running fans only; a nonzero demand once it clears the deadband
  function automatic bit command_due(logic [PCT_W-1:0] dem, logic [PCT_W-1:0] last);
    int step_size;
    step_size = int'(dem) - int'(last);
    if (step_size < 0) step_size = -step_size;
    return (dem == PCT_ZERO && last != PCT_ZERO) ||
           (dem != PCT_ZERO && step_size >= int'(cfg_shadow[CFG_DEADBAND][PCT_W-1:0]));
  endfunction

  // Work out the result of one tick and advance the model's last commands
  function automatic fan_cmd_t predict_fan_commands(fan_reading_t r);
    fan_cmd_t             c;
    logic signed [TW-1:0] board_t;
    logic [PCT_W-1:0]     cap_dem;
    logic [PCT_W-1:0]     sink_dem;
    cap_dem  = cap_cmd_now;
    sink_dem = sink_cmd_now;
    if (!r.supply) begin
      // Supply gone: stop both, flag only fans that were running
      c.cap_wr     = (cap_cmd_now != PCT_ZERO);
      c.sink_wr    = (sink_cmd_now != PCT_ZERO);
      cap_cmd_now  = PCT_ZERO;
      sink_cmd_now = PCT_ZERO;
    end else begin
      if (r.a_valid || r.b_valid) begin
        // Follow the hotter of the valid board sensors
        board_t = r.a_valid ? r.a_temp : r.b_temp;
        if (r.a_valid && r.b_valid && r.b_temp > r.a_temp) board_t = r.b_temp;
        cap_dem = fan_demand(board_t, cfg_shadow[CFG_CAP_OFF], cfg_shadow[CFG_CAP_ON],
                             cfg_shadow[CFG_CAP_FULL], cap_cmd_now);
      end
      if (r.sink_valid) begin
        sink_dem = fan_demand(r.sink_temp, cfg_shadow[CFG_SINK_OFF], cfg_shadow[CFG_SINK_ON],
                              cfg_shadow[CFG_SINK_FULL], sink_cmd_now);
      end
      c.cap_wr = command_due(cap_dem, cap_cmd_now);
      if (c.cap_wr) cap_cmd_now = cap_dem;
      c.sink_wr = command_due(sink_dem, sink_cmd_now);
      if (c.sink_wr) sink_cmd_now = sink_dem;
    end
    c.cap_pct  = cap_cmd_now;
    c.sink_pct = sink_cmd_now;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_step_t tick_row(bit sup, logic signed [TW-1:0] st, bit sv,
                                          logic signed [TW-1:0] at, bit av,
                                          logic signed [TW-1:0] bt, bit bv, bit typed,
                                          logic [PCT_W-1:0] cp, bit cw,
                                          logic [PCT_W-1:0] sp, bit sw);
    plan_step_t p;
    p.is_write      = 1'b0;
    p.rd.supply     = sup;
    p.rd.sink_temp  = st;
    p.rd.sink_valid = sv;
    p.rd.a_temp     = at;
    p.rd.a_valid    = av;
    p.rd.b_temp     = bt;
    p.rd.b_valid    = bv;
    p.typed         = typed;
    p.want.cap_pct  = cp;
    p.want.cap_wr   = cw;
    p.want.sink_pct = sp;
    p.want.sink_wr  = sw;
    return p;
  endfunction

  function automatic plan_step_t reg_row(cfg_idx_t idx, logic [TW-1:0] val);
    plan_step_t p;
    p.is_write = 1'b1;
    p.idx      = idx;
    p.wdata    = val;
    p.typed    = 1'b0;
    return p;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Temperatures cluster around the curve points and drift in small steps,
  // so the ramp, the hysteresis band and the deadband all get hit
  function automatic logic signed [TW-1:0] pick_temp(logic signed [TW-1:0] prev,
                                                     logic signed [TW-1:0] off_pt,
                                                     logic signed [TW-1:0] on_pt,
                                                     logic signed [TW-1:0] full_pt);
    logic signed [TW-1:0] t;
    int r, lo, hi;
    r  = $urandom_range(0, 99);
    lo = int'(off_pt);
    if (int'(on_pt) < lo) lo = int'(on_pt);
    if (int'(full_pt) < lo) lo = int'(full_pt);
    hi = int'(off_pt);
    if (int'(on_pt) > hi) hi = int'(on_pt);
    if (int'(full_pt) > hi) hi = int'(full_pt);
    lo = lo - 64;
    hi = hi + 64;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (r < 12) begin
      t = TW'($urandom);
    end else if (r < 22) begin
      case ($urandom_range(0, 6))
        0: t = off_pt;
        1: t = TW'(off_pt + 1);
        2: t = on_pt;
        3: t = TW'(on_pt + 1);
        4: t = TW'(on_pt - 1);
        5: t = full_pt;
        default: t = TW'(full_pt - 1);
      endcase
    end else if (r < 60) begin
      t = TW'(int'(prev) + int'($urandom_range(0, 16)) - 8);
    end else begin
      t = TW'(lo + int'($urandom_range(0, hi - lo)));
    end
    return t;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string what, int want, int got);
    mismatch_count++;
    $display("[%0t] mismatch: %s: want %0d got %0d", $time, what, want, got);
  endtask

  // Write one register; the enable is high for a single cycle
  task automatic write_reg(cfg_idx_t idx, logic [TW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cfg_shadow[idx] = val;
  endtask

  // Present one tick and hold it until it is taken, then record its result.
  // Valid stays high so a following tick can go out back to back.
  task automatic send_tick(fan_reading_t r, bit typed, fan_cmd_t want);
    fan_cmd_t pred;
    in_valid          <= 1'b1;
    in_supply_present <= r.supply;
    in_sink_temp      <= r.sink_temp;
    in_sink_valid     <= r.sink_valid;
    in_board_a_temp   <= r.a_temp;
    in_board_a_valid  <= r.a_valid;
    in_board_b_temp   <= r.b_temp;
    in_board_b_valid  <= r.b_valid;
    do @(posedge clk); while (in_stall);
    pred = predict_fan_commands(r);
    if (typed) pending_cmds.push_back(want);
    else pending_cmds.push_back(pred);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  task automatic program_fan_curve(cfg_idx_t off_idx, cfg_idx_t on_idx, cfg_idx_t full_idx,
                                   curve_shape_t shape);
    int off_pt, on_pt, full_pt;
    on_pt   = int'($urandom_range(0, 4000)) - 2000;
    off_pt  = on_pt - int'($urandom_range(0, 160));
    full_pt = on_pt + int'($urandom_range(1, 800));
    case (shape)
      CURVE_FULL_SPAN: begin
        off_pt  = -32768;
        on_pt   = -32768;
        full_pt = 32767;
      end
      CURVE_STEEP: begin
        off_pt  = on_pt - int'($urandom_range(0, 4));
        full_pt = on_pt + int'($urandom_range(1, 4));
      end
      CURVE_OFF_ABOVE_ON: off_pt = on_pt + int'($urandom_range(0, 300));
      CURVE_FULL_BELOW_ON: full_pt = on_pt - int'($urandom_range(0, 300));
      CURVE_TOP_END: begin
        full_pt = 32767;
        on_pt   = 32767 - int'($urandom_range(0, 40));
        off_pt  = on_pt - int'($urandom_range(0, 40));
      end
      CURVE_WILD: begin
        off_pt  = int'($urandom_range(0, 65535)) - 32768;
        on_pt   = int'($urandom_range(0, 65535)) - 32768;
        full_pt = int'($urandom_range(0, 65535)) - 32768;
      end
      default: ;
    endcase
    write_reg(off_idx, TW'(off_pt));
    write_reg(on_idx, TW'(on_pt));
    write_reg(full_idx, TW'(full_pt));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, with long stretches of no stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(0, 4);
      end else if (r < 70) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(50, 200);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(10, 40);
      end
    end
  end

  // Compare every accepted result with the oldest pending one
  always @(posedge clk) begin : check_results
    fan_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with no tick pending, cap_percent", 0, out_cap_percent);
      end else begin
        want = pending_cmds.pop_front();
        if (out_cap_percent !== want.cap_pct)
          report_mismatch("cap_percent", want.cap_pct, out_cap_percent);
        if (out_cap_write !== want.cap_wr)
          report_mismatch("cap_write", want.cap_wr, out_cap_write);
        if (out_sink_percent !== want.sink_pct)
          report_mismatch("sink_percent", want.sink_pct, out_sink_percent);
        if (out_sink_write !== want.sink_wr)
          report_mismatch("sink_write", want.sink_wr, out_sink_write);
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_dual_fan_speed_controller_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    fan_reading_t rd;
    fan_cmd_t     no_cmd;
    curve_shape_t cap_shape, sink_shape;
    int           min_run, deadband;

    // Shadow starts at the register reset values
    cfg_shadow[CFG_CAP_OFF]   = TW'(RST_CAP_OFF);
    cfg_shadow[CFG_CAP_ON]    = TW'(RST_CAP_ON);
    cfg_shadow[CFG_CAP_FULL]  = TW'(RST_CAP_FULL);
    cfg_shadow[CFG_SINK_OFF]  = TW'(RST_SINK_OFF);
    cfg_shadow[CFG_SINK_ON]   = TW'(RST_SINK_ON);
    cfg_shadow[CFG_SINK_FULL] = TW'(RST_SINK_FULL);
    cfg_shadow[CFG_MIN_RUN]   = TW'(RST_MIN_RUN);
    cfg_shadow[CFG_DEADBAND]  = TW'(RST_DEADBAND);

    // Directed plan, at the reset curves first. Columns: supply, sink temp,
    // sink valid, board a temp/valid, board b temp/valid, then the hand
    // result (typed, cap pct, cap write, sink pct, sink write).
    // Supply lost right after reset: nothing was running, so no write
    plan.push_back(tick_row(0, 16'sd1280, 1, 16'sd1120, 1, 16'sd1120, 1,
                            1, 7'd0, 0, 7'd0, 0));
    // Both fans at their full points
    plan.push_back(tick_row(1, 16'sd1280, 1, 16'sd1120, 1, 16'sd0, 0,
                            1, 7'd100, 1, 7'd100, 1));
    // Coldest readings stop both fans
    plan.push_back(tick_row(1, 16'sh8000, 1, 16'sh8000, 1, 16'sh8000, 1,
                            1, 7'd0, 1, 7'd0, 1));
    // No valid sensor at all: hold zero, no write
    plan.push_back(tick_row(1, 16'sh7FFF, 0, 16'sd0, 0, 16'sd0, 0,
                            1, 7'd0, 0, 7'd0, 0));
    // Hottest board a vs coldest board b; sink reading missing
    plan.push_back(tick_row(1, 16'sd0, 0, 16'sh7FFF, 1, 16'sh8000, 1,
                            1, 7'd100, 1, 7'd0, 0));
    // Board b hotter; cap stays at 100 so no new command
    plan.push_back(tick_row(1, 16'sh7FFF, 1, 16'sd700, 1, 16'sh7FFF, 1,
                            1, 7'd100, 0, 7'd100, 1));
    // Supply lost with both running, then lost again
    plan.push_back(tick_row(0, 16'sd0, 1, 16'sd0, 1, 16'sd0, 1,
                            1, 7'd0, 1, 7'd0, 1));
    plan.push_back(tick_row(0, 16'sd0, 1, 16'sd0, 1, 16'sd0, 1,
                            1, 7'd0, 0, 7'd0, 0));
    // Exactly at the on points: demand zero
    plan.push_back(tick_row(1, 16'sd800, 1, 16'sd720, 1, 16'sd720, 0,
                            1, 7'd0, 0, 7'd0, 0));
    // Just above the on points: minimum run; then a half-up rounding point
    plan.push_back(tick_row(1, 16'sd801, 1, 16'sd721, 1, 16'sd600, 1, 0, 0, 0, 0, 0));
    plan.push_back(tick_row(1, 16'sd1040, 1, 16'sd922, 1, 16'sd0, 0, 0, 0, 0, 0, 0));
    // A step smaller than the deadband
    plan.push_back(tick_row(1, 16'sd1041, 1, 16'sd921, 1, 16'sd0, 0, 0, 0, 0, 0, 0));
    // Hysteresis band holds, only board b valid for the cap fan
    plan.push_back(tick_row(1, 16'sd760, 1, 16'sd700, 0, 16'sd700, 1, 0, 0, 0, 0, 0));
    // Heatsink at its off point stops; cap at its off point but b hotter
    plan.push_back(tick_row(1, 16'sd720, 1, 16'sd640, 1, 16'sd641, 1, 0, 0, 0, 0, 0));
    // Odd settings: minimum run past 100, zero deadband, cap off above on,
    // sink full below on
    plan.push_back(reg_row(CFG_MIN_RUN, 16'd127));
    plan.push_back(reg_row(CFG_DEADBAND, 16'd0));
    plan.push_back(reg_row(CFG_CAP_OFF, 16'd800));
    plan.push_back(reg_row(CFG_SINK_FULL, 16'd700));
    plan.push_back(tick_row(1, 16'sd800, 1, 16'sd721, 1, 16'sd0, 0, 0, 0, 0, 0, 0));
    plan.push_back(tick_row(1, 16'sd799, 1, 16'sd801, 1, 16'sd0, 0, 0, 0, 0, 0, 0));
    // Same reading twice: zero deadband reissues an unchanged command
    plan.push_back(tick_row(1, 16'sd900, 1, 16'sd801, 1, 16'sd0, 0, 0, 0, 0, 0, 0));
    plan.push_back(tick_row(1, 16'sd900, 1, 16'sd801, 1, 16'sd0, 0, 0, 0, 0, 0, 0));

    // Hold reset, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan; register writes wait for an idle block
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_tick(plan[i].rd, plan[i].typed, plan[i].want);
        idle_input(pick_gap());
      end
    end

    // Random phases: reprogram every register, then stream ticks
    rd.sink_temp = '0;
    rd.a_temp    = '0;
    rd.b_temp    = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          cap_shape  = CURVE_TYPICAL;
          sink_shape = CURVE_TYPICAL;
          min_run    = RST_MIN_RUN;
          deadband   = RST_DEADBAND;
        end
        1: begin
          cap_shape  = CURVE_FULL_SPAN;
          sink_shape = CURVE_FULL_SPAN;
          min_run    = 0;
          deadband   = 0;
        end
        2: begin
          cap_shape  = CURVE_STEEP;
          sink_shape = CURVE_OFF_ABOVE_ON;
          min_run    = 127;
          deadband   = 127;
        end
        3: begin
          cap_shape  = CURVE_TOP_END;
          sink_shape = CURVE_FULL_BELOW_ON;
          min_run    = 100;
          deadband   = 1;
        end
        default: begin
          cap_shape  = curve_shape_t'($urandom_range(0, 6));
          sink_shape = curve_shape_t'($urandom_range(0, 6));
          min_run    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(5, 40);
          deadband   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 6);
        end
      endcase
      program_fan_curve(CFG_CAP_OFF, CFG_CAP_ON, CFG_CAP_FULL, cap_shape);
      program_fan_curve(CFG_SINK_OFF, CFG_SINK_ON, CFG_SINK_FULL, sink_shape);
      write_reg(CFG_MIN_RUN, TW'(min_run));
      write_reg(CFG_DEADBAND, TW'(deadband));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rd.supply     = ($urandom_range(0, 99) < 92);
        rd.sink_valid = ($urandom_range(0, 99) < 85);
        rd.a_valid    = ($urandom_range(0, 99) < 85);
        rd.b_valid    = ($urandom_range(0, 99) < 85);
        rd.sink_temp  = pick_temp(rd.sink_temp, cfg_shadow[CFG_SINK_OFF],
                                  cfg_shadow[CFG_SINK_ON], cfg_shadow[CFG_SINK_FULL]);
        rd.a_temp     = pick_temp(rd.a_temp, cfg_shadow[CFG_CAP_OFF],
                                  cfg_shadow[CFG_CAP_ON], cfg_shadow[CFG_CAP_FULL]);
        rd.b_temp     = pick_temp(rd.b_temp, cfg_shadow[CFG_CAP_OFF],
                                  cfg_shadow[CFG_CAP_ON], cfg_shadow[CFG_CAP_FULL]);
        send_tick(rd, 1'b0, no_cmd);
        // Every third phase runs with no input gaps at all
        if (ph % 3 != 2) idle_input(pick_gap());
      end
    end

    // Let everything come back, then watch a while for stray results
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_cmds.size() != 0)
      report_mismatch("ticks left with no result", 0, pending_cmds.size());

    if (mismatch_count == 0) begin
      $display("tb_dual_fan_speed_controller_unit passed");
    end else begin
      $display("tb_dual_fan_speed_controller_unit failed");
    end
    $finish;
  end

endmodule
